// File: hw/rtl/m3inv_pkg.sv
// Package for the 3x3 matrix inverse unit.
// Holds default widths, the threshold register reset, cofactor index tables and
// the control struct passed from the front end through the queue to the back end.
package m3inv_pkg;

   localparam int DEF_ENTRY_WIDTH = 24;
   localparam int DEF_FRAC_BITS   = 16;
   localparam int NUM_ENTRIES     = 9;
   localparam int THRESH_WIDTH    = 40;
   localparam logic [THRESH_WIDTH-1:0] THRESH_RESET = 40'd28147498;
   localparam int QUEUE_DEPTH     = 8;
   localparam int FRONT_STAGES    = 6;

   typedef logic [3:0] idx_type;

   // Cofactor k is m[A]*m[B] - m[C]*m[D], row-major entry numbering.
   localparam idx_type CF_A [NUM_ENTRIES] = '{4'd4, 4'd2, 4'd1, 4'd5, 4'd0, 4'd2, 4'd3, 4'd1, 4'd0};
   localparam idx_type CF_B [NUM_ENTRIES] = '{4'd8, 4'd7, 4'd5, 4'd6, 4'd8, 4'd3, 4'd7, 4'd6, 4'd4};
   localparam idx_type CF_C [NUM_ENTRIES] = '{4'd5, 4'd1, 4'd2, 4'd3, 4'd2, 4'd0, 4'd4, 4'd0, 4'd1};
   localparam idx_type CF_D [NUM_ENTRIES] = '{4'd7, 4'd8, 4'd4, 4'd8, 4'd6, 4'd5, 4'd6, 4'd7, 4'd3};

   typedef struct packed {
      logic singular;
      logic det_neg;
   } m3inv_ctl_type;

endpackage

// File: hw/rtl/matrix3_inverse_unit.sv
// Top level of the 3x3 matrix inverse unit (adjugate over determinant).
// Instantiates m3inv_front, m3inv_queue and m3inv_back; depends on m3inv_pkg.
//
//   Channel   Ports              Handshake
//   request   start, req_m*      taken when start is high and busy is low
//   response  rsp_valid, rsp_*   one-cycle strobe, cannot be held off
//   control   csr_we, csr_wdata  written when csr_we is high
//
// A new matrix is taken every cycle while busy is low. Each result passes through
// the six-stage cofactor and determinant front end, the queue, and the division
// lanes that resolve one quotient bit per stage.
// Reset is synchronous, clears the pipelines and the queue, and restores the threshold.
// busy rises only when the queue could not absorb the items in the front end.
module matrix3_inverse_unit
   import m3inv_pkg::*;
#(
   parameter int ENTRY_WIDTH = DEF_ENTRY_WIDTH,
   parameter int FRAC_BITS   = DEF_FRAC_BITS
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic signed [ENTRY_WIDTH-1:0] req_m11,
   input  logic signed [ENTRY_WIDTH-1:0] req_m12,
   input  logic signed [ENTRY_WIDTH-1:0] req_m13,
   input  logic signed [ENTRY_WIDTH-1:0] req_m21,
   input  logic signed [ENTRY_WIDTH-1:0] req_m22,
   input  logic signed [ENTRY_WIDTH-1:0] req_m23,
   input  logic signed [ENTRY_WIDTH-1:0] req_m31,
   input  logic signed [ENTRY_WIDTH-1:0] req_m32,
   input  logic signed [ENTRY_WIDTH-1:0] req_m33,
   input  logic                          csr_we,
   input  logic [THRESH_WIDTH-1:0]       csr_wdata,
   output logic                          rsp_valid,
   output logic signed [ENTRY_WIDTH-1:0] rsp_r11,
   output logic signed [ENTRY_WIDTH-1:0] rsp_r12,
   output logic signed [ENTRY_WIDTH-1:0] rsp_r13,
   output logic signed [ENTRY_WIDTH-1:0] rsp_r21,
   output logic signed [ENTRY_WIDTH-1:0] rsp_r22,
   output logic signed [ENTRY_WIDTH-1:0] rsp_r23,
   output logic signed [ENTRY_WIDTH-1:0] rsp_r31,
   output logic signed [ENTRY_WIDTH-1:0] rsp_r32,
   output logic signed [ENTRY_WIDTH-1:0] rsp_r33,
   output logic                          rsp_singular
);

   localparam int EW   = ENTRY_WIDTH;
   localparam int AW   = 2*EW+1;
   localparam int DW   = 3*EW+3;
   localparam int QDW  = NUM_ENTRIES*AW + DW;
   localparam int CNTW = $clog2(QUEUE_DEPTH+1);
   localparam logic [CNTW-1:0] BUSY_LEVEL = CNTW'(QUEUE_DEPTH - FRONT_STAGES);

   logic [THRESH_WIDTH-1:0]       thresh_ff, thresh_in;
   logic [NUM_ENTRIES*EW-1:0]     m_flat, res_flat;
   logic                          fr_valid, q_valid;
   m3inv_ctl_type                 fr_ctl, q_ctl;
   logic [NUM_ENTRIES*AW-1:0]     fr_adj;
   logic [DW-1:0]                 fr_mag;
   logic [QDW-1:0]                q_data;
   logic [CNTW-1:0]               q_count;

   assign thresh_in = csr_we ? csr_wdata : thresh_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         thresh_ff <= THRESH_RESET;
      end else begin
         thresh_ff <= thresh_in;
      end
   end

   assign busy   = (q_count >= BUSY_LEVEL);
   assign m_flat = {req_m33, req_m32, req_m31, req_m23, req_m22, req_m21,
                    req_m13, req_m12, req_m11};

   m3inv_front #(
      .EW(EW),
      .FB(FRAC_BITS)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .in_valid (start & ~busy),
      .m_flat   (m_flat),
      .thresh   (thresh_ff),
      .out_valid(fr_valid),
      .out_ctl  (fr_ctl),
      .out_adj  (fr_adj),
      .out_mag  (fr_mag)
   );

   m3inv_queue #(
      .WIDTH(QDW),
      .DEPTH(QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (fr_valid),
      .push_ctl (fr_ctl),
      .push_data({fr_mag, fr_adj}),
      .pop_valid(q_valid),
      .pop_ctl  (q_ctl),
      .pop_data (q_data),
      .count    (q_count)
   );

   m3inv_back #(
      .EW(EW),
      .FB(FRAC_BITS)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (q_valid),
      .in_ctl      (q_ctl),
      .in_adj      (q_data[NUM_ENTRIES*AW-1:0]),
      .in_mag      (q_data[QDW-1:NUM_ENTRIES*AW]),
      .out_valid   (rsp_valid),
      .out_res     (res_flat),
      .out_singular(rsp_singular)
   );

   assign rsp_r11 = res_flat[0*EW +: EW];
   assign rsp_r12 = res_flat[1*EW +: EW];
   assign rsp_r13 = res_flat[2*EW +: EW];
   assign rsp_r21 = res_flat[3*EW +: EW];
   assign rsp_r22 = res_flat[4*EW +: EW];
   assign rsp_r23 = res_flat[5*EW +: EW];
   assign rsp_r31 = res_flat[6*EW +: EW];
   assign rsp_r32 = res_flat[7*EW +: EW];
   assign rsp_r33 = res_flat[8*EW +: EW];

`ifndef SYNTHESIS
   a_singular_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_singular |-> rsp_r11 == '0 && rsp_r12 == '0 && rsp_r13 == '0 &&
         rsp_r21 == '0 && rsp_r22 == '0 && rsp_r23 == '0 && rsp_r31 == '0 &&
         rsp_r32 == '0 && rsp_r33 == '0)
      else $error("singular item carries nonzero entries");

   a_queue_drains: assert property (@(posedge clock) disable iff (reset)
      q_count <= CNTW'(1))
      else $error("queue holds more than one item");

   a_never_busy: assert property (@(posedge clock) disable iff (reset)
      $past(fr_valid) && !$past(reset) |-> !busy)
      else $error("unit stalled the request side");
`endif

endmodule

// File: hw/rtl/m3inv_front.sv
// Front end of the 3x3 matrix inverse unit: cofactors, determinant, singular test.
// Six register stages, one item per cycle. Depends on m3inv_pkg.
module m3inv_front
   import m3inv_pkg::*;
#(
   parameter int EW = DEF_ENTRY_WIDTH,
   parameter int FB = DEF_FRAC_BITS
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      in_valid,
   input  logic [NUM_ENTRIES*EW-1:0] m_flat,
   input  logic [THRESH_WIDTH-1:0]   thresh,
   output logic                      out_valid,
   output m3inv_ctl_type             out_ctl,
   output logic [NUM_ENTRIES*(2*EW+1)-1:0] out_adj,
   output logic [3*EW+2:0]           out_mag
);

   localparam int AW     = 2*EW+1;
   localparam int DW     = 3*EW+3;
   localparam int PW     = 2*EW;
   localparam int LW     = 2*EW+2;
   localparam int CW     = DW+64;
   localparam int MAG_SH = (3*FB >= 48) ? 0 : 48-3*FB;
   localparam int THR_SH = (3*FB >= 48) ? 3*FB-48 : 0;

   logic signed [EW-1:0] m_w [NUM_ENTRIES];

   logic                 v1_ff, v1_in, v2_ff, v2_in, v3_ff, v3_in;
   logic                 v4_ff, v4_in, v5_ff, v5_in, v6_ff, v6_in;
   logic signed [PW-1:0] pa1_ff [NUM_ENTRIES], pa1_in [NUM_ENTRIES];
   logic signed [PW-1:0] pb1_ff [NUM_ENTRIES], pb1_in [NUM_ENTRIES];
   logic signed [EW-1:0] mc1_ff [3], mc1_in [3], mc2_ff [3], mc2_in [3];
   logic signed [AW-1:0] adj2_ff [NUM_ENTRIES], adj2_in [NUM_ENTRIES];
   logic signed [AW-1:0] adj3_ff [NUM_ENTRIES], adj3_in [NUM_ENTRIES];
   logic signed [AW-1:0] adj4_ff [NUM_ENTRIES], adj4_in [NUM_ENTRIES];
   logic signed [AW-1:0] adj5_ff [NUM_ENTRIES], adj5_in [NUM_ENTRIES];
   logic signed [AW-1:0] adj6_ff [NUM_ENTRIES], adj6_in [NUM_ENTRIES];
   logic signed [LW-1:0] lo3_ff [3], lo3_in [3];
   logic signed [PW-1:0] hi3_ff [3], hi3_in [3];
   logic signed [DW-1:0] term4_ff [3], term4_in [3];
   logic signed [DW-1:0] det5_ff, det5_in;
   logic [DW-1:0]        mag6_ff, mag6_in, mag_w;
   m3inv_ctl_type        ctl6_ff, ctl6_in;
   logic [CW-1:0]        lhs_w, rhs_w;

   always_comb begin
      for (int k = 0; k < NUM_ENTRIES; k++) begin
         m_w[k] = m_flat[k*EW +: EW];
      end
      v1_in = in_valid;
      v2_in = v1_ff;
      v3_in = v2_ff;
      v4_in = v3_ff;
      v5_in = v4_ff;
      v6_in = v5_ff;
      for (int k = 0; k < NUM_ENTRIES; k++) begin
         pa1_in[k]  = m_w[CF_A[k]] * m_w[CF_B[k]];
         pb1_in[k]  = m_w[CF_C[k]] * m_w[CF_D[k]];
         adj2_in[k] = AW'(pa1_ff[k]) - AW'(pb1_ff[k]);
         adj3_in[k] = adj2_ff[k];
         adj4_in[k] = adj3_ff[k];
         adj5_in[k] = adj4_ff[k];
         adj6_in[k] = adj5_ff[k];
      end
      for (int t = 0; t < 3; t++) begin
         mc1_in[t]   = m_w[3*t];
         mc2_in[t]   = mc1_ff[t];
         lo3_in[t]   = mc2_ff[t] * $signed({1'b0, adj2_ff[t][EW:0]});
         hi3_in[t]   = mc2_ff[t] * $signed(adj2_ff[t][AW-1:EW+1]);
         term4_in[t] = (DW'(hi3_ff[t]) <<< (EW+1)) + DW'(lo3_ff[t]);
      end
      det5_in = term4_ff[0] + term4_ff[1] + term4_ff[2];
      mag_w   = det5_ff[DW-1] ? DW'(-det5_ff) : DW'(det5_ff);
      lhs_w   = CW'(mag_w) << MAG_SH;
      rhs_w   = CW'(thresh) << THR_SH;
      mag6_in = mag_w;
      ctl6_in.det_neg  = det5_ff[DW-1];
      ctl6_in.singular = (mag_w == '0) || (lhs_w < rhs_w);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
         v6_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         v3_ff <= v3_in;
         v4_ff <= v4_in;
         v5_ff <= v5_in;
         v6_ff <= v6_in;
      end
   end

   always_ff @(posedge clock) begin
      pa1_ff   <= pa1_in;
      pb1_ff   <= pb1_in;
      mc1_ff   <= mc1_in;
      mc2_ff   <= mc2_in;
      adj2_ff  <= adj2_in;
      adj3_ff  <= adj3_in;
      adj4_ff  <= adj4_in;
      adj5_ff  <= adj5_in;
      adj6_ff  <= adj6_in;
      lo3_ff   <= lo3_in;
      hi3_ff   <= hi3_in;
      term4_ff <= term4_in;
      det5_ff  <= det5_in;
      mag6_ff  <= mag6_in;
      ctl6_ff  <= ctl6_in;
   end

   always_comb begin
      for (int k = 0; k < NUM_ENTRIES; k++) begin
         out_adj[k*AW +: AW] = adj6_ff[k];
      end
   end

   assign out_valid = v6_ff;
   assign out_ctl   = ctl6_ff;
   assign out_mag   = mag6_ff;

endmodule

// File: hw/rtl/m3inv_queue.sv
// Short queue between the front end and the back end of the matrix inverse unit.
// The head is popped whenever the queue holds an item. Depends on m3inv_pkg.
module m3inv_queue
   import m3inv_pkg::*;
#(
   parameter int WIDTH = 8,
   parameter int DEPTH = QUEUE_DEPTH
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  m3inv_ctl_type              push_ctl,
   input  logic [WIDTH-1:0]           push_data,
   output logic                       pop_valid,
   output m3inv_ctl_type              pop_ctl,
   output logic [WIDTH-1:0]           pop_data,
   output logic [$clog2(DEPTH+1)-1:0] count
);

   localparam int PTRW = $clog2(DEPTH);
   localparam int CNTW = $clog2(DEPTH+1);
   localparam int EWID = WIDTH + $bits(m3inv_ctl_type);

   logic [EWID-1:0] mem_ff [DEPTH];
   logic [PTRW-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNTW-1:0] count_ff, count_in;
   logic            pop;

   always_comb begin
      pop       = (count_ff != '0);
      wr_ptr_in = push ? wr_ptr_ff + PTRW'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + PTRW'(1) : rd_ptr_ff;
      count_in  = count_ff + CNTW'(push) - CNTW'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= {push_ctl, push_data};
      end
   end

   assign pop_valid = pop;
   assign {pop_ctl, pop_data} = mem_ff[rd_ptr_ff];
   assign count = count_ff;

endmodule

// File: hw/rtl/m3inv_div_lane.sv
// One division lane: rounded, saturated quotient of a cofactor by the determinant.
// Restoring division, one quotient bit per pipeline stage. Depends on m3inv_pkg.
module m3inv_div_lane
   import m3inv_pkg::*;
#(
   parameter int EW = DEF_ENTRY_WIDTH,
   parameter int FB = DEF_FRAC_BITS
) (
   input  logic                 clock,
   input  logic signed [2*EW:0] adj,
   input  logic [3*EW+2:0]      mag,
   input  logic                 det_neg,
   output logic signed [EW-1:0] res
);

   localparam int AW = 2*EW+1;
   localparam int DW = 3*EW+3;
   localparam int RW = DW+EW+3;
   localparam int NS = EW+2;
   localparam int QW = EW+2;
   localparam logic [QW-1:0] NEG_LIM = QW'(1) << (EW-1);
   localparam logic [QW-1:0] POS_LIM = NEG_LIM - QW'(1);

   logic [RW-1:0]  rem_ff [NS+1], rem_in [NS+1];
   logic [QW-1:0]  q_ff [NS+1], q_in [NS+1];
   logic [DW:0]    dd_ff [NS+1], dd_in [NS+1];
   logic           neg_ff [NS+1], neg_in [NS+1];
   logic [AW-1:0]  aabs_w;
   logic [QW-1:0]  qsat_w;
   logic signed [EW-1:0] res_ff, res_in;

   always_comb begin
      aabs_w    = adj[AW-1] ? AW'(-adj) : AW'(adj);
      rem_in[0] = (RW'(aabs_w) << (FB+1)) + RW'(mag);
      dd_in[0]  = {mag, 1'b0};
      q_in[0]   = '0;
      neg_in[0] = adj[AW-1] ^ det_neg;
   end

   for (genvar s = 0; s < NS; s++) begin : g_step
      localparam int SH = NS-1-s;
      logic [RW-1:0] cmp;
      logic          ge;
      assign cmp          = RW'(dd_ff[s]) << SH;
      assign ge           = (rem_ff[s] >= cmp);
      assign rem_in[s+1]  = ge ? rem_ff[s] - cmp : rem_ff[s];
      assign q_in[s+1]    = q_ff[s] | (QW'(ge) << SH);
      assign dd_in[s+1]   = dd_ff[s];
      assign neg_in[s+1]  = neg_ff[s];
   end

   always_comb begin
      if (neg_ff[NS]) begin
         qsat_w = (q_ff[NS] > NEG_LIM) ? NEG_LIM : q_ff[NS];
         res_in = EW'(-qsat_w);
      end else begin
         qsat_w = (q_ff[NS] > POS_LIM) ? POS_LIM : q_ff[NS];
         res_in = EW'(qsat_w);
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      q_ff   <= q_in;
      dd_ff  <= dd_in;
      neg_ff <= neg_in;
      res_ff <= res_in;
   end

   assign res = res_ff;

endmodule

// File: hw/rtl/m3inv_back.sv
// Back end of the matrix inverse unit: nine division lanes and the result register.
// Singular items pass through the lanes and leave as zeros. Depends on m3inv_pkg.
module m3inv_back
   import m3inv_pkg::*;
#(
   parameter int EW = DEF_ENTRY_WIDTH,
   parameter int FB = DEF_FRAC_BITS
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            in_valid,
   input  m3inv_ctl_type                   in_ctl,
   input  logic [NUM_ENTRIES*(2*EW+1)-1:0] in_adj,
   input  logic [3*EW+2:0]                 in_mag,
   output logic                            out_valid,
   output logic [NUM_ENTRIES*EW-1:0]       out_res,
   output logic                            out_singular
);

   localparam int AW  = 2*EW+1;
   localparam int LAT = EW+4;

   logic signed [EW-1:0] lane_res [NUM_ENTRIES];
   logic                 vld_ff [LAT], vld_in [LAT];
   logic                 sing_ff [LAT], sing_in [LAT];
   logic                 out_valid_ff, out_valid_in, out_sing_ff, out_sing_in;
   logic signed [EW-1:0] res_ff [NUM_ENTRIES], res_in [NUM_ENTRIES];

   for (genvar k = 0; k < NUM_ENTRIES; k++) begin : g_lane
      m3inv_div_lane #(
         .EW(EW),
         .FB(FB)
      ) u_lane (
         .clock  (clock),
         .adj    (in_adj[k*AW +: AW]),
         .mag    (in_mag),
         .det_neg(in_ctl.det_neg),
         .res    (lane_res[k])
      );
   end

   always_comb begin
      vld_in[0]  = in_valid;
      sing_in[0] = in_ctl.singular;
      for (int i = 1; i < LAT; i++) begin
         vld_in[i]  = vld_ff[i-1];
         sing_in[i] = sing_ff[i-1];
      end
      out_valid_in = vld_ff[LAT-1];
      out_sing_in  = sing_ff[LAT-1];
      for (int k = 0; k < NUM_ENTRIES; k++) begin
         res_in[k] = sing_ff[LAT-1] ? '0 : lane_res[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < LAT; i++) begin
            vld_ff[i] <= 1'b0;
         end
         out_valid_ff <= 1'b0;
      end else begin
         vld_ff       <= vld_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      sing_ff     <= sing_in;
      out_sing_ff <= out_sing_in;
      res_ff      <= res_in;
   end

   always_comb begin
      for (int k = 0; k < NUM_ENTRIES; k++) begin
         out_res[k*EW +: EW] = res_ff[k];
      end
   end

   assign out_valid    = out_valid_ff;
   assign out_singular = out_sing_ff;

endmodule

// File: tb/sv/testbench.sv
// Self-checking testbench for matrix3_inverse_unit, the 3x3 inverse by adjugate.
// Drives matrices through start/busy, predicts each inverse and checks every strobe.
// Depends on m3inv_pkg and the matrix3_inverse_unit RTL.
`timescale 1ns / 1ps

module testbench;
   import m3inv_pkg::*;

   localparam int EW = DEF_ENTRY_WIDTH;
   localparam int FB = DEF_FRAC_BITS;
   localparam logic [EW-1:0] ENTRY_MAX = {1'b0, {(EW-1){1'b1}}};
   localparam logic [EW-1:0] ENTRY_MIN = {1'b1, {(EW-1){1'b0}}};
   localparam logic [EW-1:0] ONE = 24'sd65536;

   typedef logic [8:0][EW-1:0] matrix_type;

   typedef struct packed {
      logic       singular;
      matrix_type entries;
   } inverse_type;

   typedef struct {
      bit                      is_write;
      logic [THRESH_WIDTH-1:0] threshold;
      matrix_type              m;
      bit                      has_known;
      inverse_type             known;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic csr_we = 1'b0;
   logic [THRESH_WIDTH-1:0] csr_wdata = '0;
   matrix_type req_m = '0;
   logic rsp_valid;
   matrix_type rsp_r;
   logic rsp_singular;

   logic [THRESH_WIDTH-1:0] threshold_model;
   inverse_type expected_inverses[$];
   int failures = 0;

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   matrix3_inverse_unit i_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_m11(req_m[0]), .req_m12(req_m[1]), .req_m13(req_m[2]),
      .req_m21(req_m[3]), .req_m22(req_m[4]), .req_m23(req_m[5]),
      .req_m31(req_m[6]), .req_m32(req_m[7]), .req_m33(req_m[8]),
      .csr_we(csr_we), .csr_wdata(csr_wdata),
      .rsp_valid(rsp_valid),
      .rsp_r11(rsp_r[0]), .rsp_r12(rsp_r[1]), .rsp_r13(rsp_r[2]),
      .rsp_r21(rsp_r[3]), .rsp_r22(rsp_r[4]), .rsp_r23(rsp_r[5]),
      .rsp_r31(rsp_r[6]), .rsp_r32(rsp_r[7]), .rsp_r33(rsp_r[8]),
      .rsp_singular(rsp_singular)
   );

   function automatic inverse_type invert_matrix(input matrix_type m);
      logic signed [127:0] e [9];
      logic signed [127:0] cof [9];
      logic signed [127:0] det;
      logic [127:0] mag, num, q;
      logic [EW-1:0] v;
      bit neg;
      inverse_type r;
      for (int i = 0; i < 9; i++) e[i] = $signed(m[i]);
      cof[0] = e[4] * e[8] - e[5] * e[7];
      cof[1] = e[2] * e[7] - e[1] * e[8];
      cof[2] = e[1] * e[5] - e[2] * e[4];
      cof[3] = e[5] * e[6] - e[3] * e[8];
      cof[4] = e[0] * e[8] - e[2] * e[6];
      cof[5] = e[2] * e[3] - e[0] * e[5];
      cof[6] = e[3] * e[7] - e[4] * e[6];
      cof[7] = e[1] * e[6] - e[0] * e[7];
      cof[8] = e[0] * e[4] - e[1] * e[3];
      det = e[0] * cof[0] + e[3] * cof[1] + e[6] * cof[2];
      mag = det < 0 ? -det : det;
      r = '0;
      if (mag == 0 || mag < {88'd0, threshold_model}) begin
         r.singular = 1'b1;
         return r;
      end
      for (int i = 0; i < 9; i++) begin
         neg = (cof[i] < 0) != (det < 0);
         num = (cof[i] < 0 ? -cof[i] : cof[i]);
         num = num << (FB + 1);
         q = (num + mag) / (mag << 1);
         if (neg) begin
            v = (q > {104'd0, ENTRY_MIN}) ? ENTRY_MIN : -q[EW-1:0];
         end else begin
            v = (q > {104'd0, ENTRY_MAX}) ? ENTRY_MAX : q[EW-1:0];
         end
         r.entries[i] = v;
      end
      return r;
   endfunction

   always @(posedge clock) begin
      inverse_type want;
      if (!reset && rsp_valid) begin
         if (expected_inverses.size() == 0) begin
            $display("%0t: unexpected item, actual singular=%0d", $time, rsp_singular);
            failures++;
         end else begin
            want = expected_inverses.pop_front();
            for (int i = 0; i < 9; i++) begin
               if (rsp_r[i] !== want.entries[i]) begin
                  $display("%0t: r%0d%0d expected %0d actual %0d", $time, i / 3 + 1,
                           i % 3 + 1, $signed(want.entries[i]), $signed(rsp_r[i]));
                  failures++;
               end
            end
            if (rsp_singular !== want.singular) begin
               $display("%0t: singular expected %0d actual %0d", $time, want.singular,
                        rsp_singular);
               failures++;
            end
         end
      end
   end

   task automatic drain();
      start <= 1'b0;
      while (expected_inverses.size() != 0) @(posedge clock);
      repeat (EW + 20) @(posedge clock);
   endtask

   task automatic write_threshold(input logic [THRESH_WIDTH-1:0] value);
      drain();
      csr_we <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      threshold_model = value;
   endtask

   task automatic send_matrix(input matrix_type m, input bit has_known,
                              input inverse_type known, input int gap);
      inverse_type pred;
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start <= 1'b1;
      req_m <= m;
      pred = invert_matrix(m);
      if (has_known && pred !== known) begin
         $display("%0t: table row disagrees with prediction, expected %h actual %h",
                  $time, known, pred);
         failures++;
      end
      @(posedge clock);
      while (busy) @(posedge clock);
      expected_inverses.push_back(pred);
   endtask

   function automatic logic [EW-1:0] small_entry();
      return EW'($signed($urandom_range(0, 1 << 19)) - (1 << 18));
   endfunction

   function automatic matrix_type random_matrix();
      matrix_type m;
      int kind;
      kind = $urandom_range(0, 9);
      for (int i = 0; i < 9; i++) m[i] = small_entry();
      case (kind)
         0, 1: begin
            for (int i = 0; i < 9; i++) m[i] = EW'($urandom);
         end
         2, 3: begin
            for (int i = 0; i < 3; i++) m[6 + i] = m[i] + m[3 + i] + EW'($urandom_range(0, 7));
         end
         4: begin
            for (int i = 0; i < 9; i++) m[i] = EW'($signed($urandom_range(0, 64)) - 32);
         end
         5: begin
            for (int i = 0; i < 9; i++) m[i] = EW'($signed($urandom_range(0, 2048)) - 1024);
            m[0] = EW'($urandom); m[4] = EW'($urandom); m[8] = EW'($urandom);
         end
         default: begin
         end
      endcase
      return m;
   endfunction

   function automatic matrix_type diagonal(input logic [EW-1:0] a, input logic [EW-1:0] b,
                                           input logic [EW-1:0] c);
      matrix_type m;
      m = '0;
      m[0] = a;
      m[4] = b;
      m[8] = c;
      return m;
   endfunction

   initial begin
      stim_row_type rows[$];
      stim_row_type row;
      inverse_type none;
      int gap_mode;
      int gap;
      none = '0;

      row = '{0, '0, '0, 1, '{1'b1, '0}};
      rows.push_back(row);
      row.m = diagonal(ONE, ONE, ONE);
      row.known = '{1'b0, diagonal(24'd1, 24'd1, 24'd1)};
      rows.push_back(row);
      row.m = diagonal(ONE << 1, ONE << 1, ONE << 1);
      row.known = '{1'b0, diagonal(24'd1, 24'd1, 24'd1)};
      rows.push_back(row);
      row.m = {9{ENTRY_MAX}};
      row.known = '{1'b1, '0};
      rows.push_back(row);
      row.m = {9{ENTRY_MIN}};
      rows.push_back(row);
      row.m = diagonal(24'd1, 24'd1, 24'd1);
      rows.push_back(row);
      row = '{0, '0, diagonal(ENTRY_MIN, ENTRY_MIN, ENTRY_MIN), 0, none};
      rows.push_back(row);
      row.m = diagonal(ENTRY_MAX, ENTRY_MIN, ENTRY_MAX);
      rows.push_back(row);
      row.m = {ENTRY_MAX, ENTRY_MIN, ENTRY_MAX, ENTRY_MIN, ENTRY_MAX,
               ENTRY_MAX, ENTRY_MIN, ENTRY_MIN, ENTRY_MIN};
      rows.push_back(row);
      row.m = {24'h000100, 24'h000200, 24'h000300, 24'h000400, 24'h000500,
               24'h000600, 24'h000700, 24'h000800, 24'h000A00};
      rows.push_back(row);
      row = '{1, '0, '0, 0, none};
      rows.push_back(row);
      row = '{0, '0, '0, 1, '{1'b1, '0}};
      rows.push_back(row);
      row.m = diagonal(24'd1, 24'd1, 24'd1);
      row.known = '{1'b0, diagonal(ONE, ONE, ONE)};
      rows.push_back(row);
      row.m = diagonal(-24'sd1, 24'd1, 24'd1);
      row.known = '{1'b0, diagonal(-ONE, ONE, ONE)};
      rows.push_back(row);
      row = '{0, '0, {24'h000001, 24'h0, 24'h0, 24'h0, 24'h0, 24'h000001,
                      24'h0, 24'h000001, 24'h0}, 0, none};
      rows.push_back(row);
      row = '{1, {THRESH_WIDTH{1'b1}}, '0, 0, none};
      rows.push_back(row);
      row = '{0, '0, diagonal(ONE, ONE, ONE), 1, '{1'b0, diagonal(24'd1, 24'd1, 24'd1)}};
      rows.push_back(row);
      row.m = diagonal(24'h002000, 24'h002000, 24'h002000);
      row.known = '{1'b1, '0};
      rows.push_back(row);
      row = '{0, '0, diagonal(24'h002800, 24'h002800, 24'h002800), 0, none};
      rows.push_back(row);

      threshold_model = THRESH_RESET;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (rows[i]) begin
         if (rows[i].is_write) begin
            write_threshold(rows[i].threshold);
         end else begin
            send_matrix(rows[i].m, rows[i].has_known, rows[i].known, $urandom_range(0, 2));
         end
      end

      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: write_threshold(THRESH_RESET);
            1: write_threshold('0);
            2: write_threshold({THRESH_WIDTH{1'b1}});
            default: write_threshold({8'($urandom_range(0, 255)), $urandom});
         endcase
         gap_mode = 0;
         for (int n = 0; n < 410; n++) begin
            if (n % 40 == 0) gap_mode = $urandom_range(0, 2);
            if (n == 200 && phase == 1) begin
               start <= 1'b0;
               while (expected_inverses.size() != 0) @(posedge clock);
            end
            gap = gap_mode == 0 ? 0 : $urandom_range(0, 14);
            send_matrix(random_matrix(), 0, none, gap);
         end
      end
      start <= 1'b0;

      while (expected_inverses.size() != 0) @(posedge clock);
      repeat (EW + 20) @(posedge clock);
      if (failures == 0) begin
         $display("** matrix3_inverse_unit: PASSED **");
      end else begin
         $display("** matrix3_inverse_unit: FAILED **");
      end
      $finish;
   end

   initial begin
      #20ms;
      $display("** matrix3_inverse_unit: FAILED **");
      $finish;
   end

endmodule

// File: files.f
hw/rtl/m3inv_pkg.sv
hw/rtl/m3inv_front.sv
hw/rtl/m3inv_queue.sv
hw/rtl/m3inv_div_lane.sv
hw/rtl/m3inv_back.sv
hw/rtl/matrix3_inverse_unit.sv
tb/sv/testbench.sv
